@@ hw/rtl/vwd_pkg.sv @@
// Package for the visibility window detector: widths, class and kind codes,
// register indexes and the result record type. No dependencies.
`default_nettype none
package vwd_pkg;
    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [2:0] CLS_VISIBLE = 3'd0;
    localparam logic [2:0] CLS_BEFORE  = 3'd1;
    localparam logic [2:0] CLS_AFTER   = 3'd2;
    localparam logic [2:0] CLS_SHADOW  = 3'd3;
    localparam logic [2:0] CLS_LOW     = 3'd4;
    localparam logic [2:0] CLS_DIM     = 3'd5;
    localparam logic [2:0] CLS_FAST    = 3'd6;
    localparam logic [2:0] CLS_MOON    = 3'd7;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_ENTRY  = 2'd1;
    localparam logic [1:0] KIND_PEAK   = 2'd2;
    localparam logic [1:0] KIND_EXIT   = 2'd3;

    localparam logic [2:0] REG_START    = 3'd0;
    localparam logic [2:0] REG_STOP     = 3'd1;
    localparam logic [2:0] REG_MIN_H    = 3'd2;
    localparam logic [2:0] REG_MAX_MAG  = 3'd3;
    localparam logic [2:0] REG_RA_RATE  = 3'd4;
    localparam logic [2:0] REG_DE_RATE  = 3'd5;
    localparam logic [2:0] REG_MOON_LO  = 3'd6;
    localparam logic [2:0] REG_MOON_HI  = 3'd7;

    // One reported sample.
    typedef struct packed {
        logic [31:0]        time_v;
        logic signed [14:0] height;
        logic signed [12:0] magnitude;
        logic signed [15:0] ra_rate;
        logic signed [15:0] decl_rate;
        logic [16:0]        ra_position;
    } t_rec;

    // One result item.
    typedef struct packed {
        logic [1:0] event_kind;
        logic [2:0] reason;
        t_rec       rec;
        logic       last_of_run;
    } t_event;
endpackage
`default_nettype wire

@@ hw/rtl/vwd_sample_if.sv @@
// Input channel: one ephemeris sample per item. Depends on nothing.
`default_nettype none
interface vwd_sample_if;
    logic               valid;
    logic               ready;
    logic [31:0]        sample_time;
    logic               in_shadow;
    logic signed [14:0] height;
    logic signed [12:0] magnitude;
    logic signed [15:0] ra_rate;
    logic signed [15:0] decl_rate;
    logic [16:0]        ra_position;
    logic               last_sample;
    modport source (output valid, sample_time, in_shadow, height, magnitude, ra_rate,
                    decl_rate, ra_position, last_sample, input ready);
    modport sink (input valid, sample_time, in_shadow, height, magnitude, ra_rate,
                  decl_rate, ra_position, last_sample, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/vwd_event_if.sv @@
// Output channel: one result record per item. Depends on nothing.
`default_nettype none
interface vwd_event_if;
    logic               valid;
    logic               ready;
    logic [1:0]         event_kind;
    logic [2:0]         reason;
    logic [31:0]        event_time;
    logic signed [14:0] event_height;
    logic signed [12:0] event_magnitude;
    logic signed [15:0] event_ra_rate;
    logic signed [15:0] event_decl_rate;
    logic [16:0]        event_ra_position;
    logic               last_of_run;
    modport source (output valid, event_kind, reason, event_time, event_height,
                    event_magnitude, event_ra_rate, event_decl_rate, event_ra_position,
                    last_of_run, input ready);
    modport sink (input valid, event_kind, reason, event_time, event_height,
                  event_magnitude, event_ra_rate, event_decl_rate, event_ra_position,
                  last_of_run, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/vwd_front.sv @@
// Front end: registers, sample classification and run tracking; pushes up to
// four result records per sample. Depends on vwd_pkg.
`default_nettype none
module vwd_front #(
    parameter int TIME_BITS = vwd_pkg::TIME_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire [vwd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [vwd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    vwd_sample_if.sink                      s_in,
    input  wire [2:0]                       i_free,
    output logic [2:0]                      o_push_n,
    output vwd_pkg::t_event                 o_ev [4]
);
    localparam int TB = (TIME_BITS > 32) ? 32 : TIME_BITS;

    logic [31:0]        r_start, r_stop, r_ra_b, r_de_b;
    logic signed [14:0] r_min_h;
    logic signed [12:0] r_max_mag;
    logic [16:0]        r_moon_lo, r_moon_hi;

    logic [2:0]      r_prev_cls;
    vwd_pkg::t_rec   r_prev, r_peak;

    // Write configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= '0;
            r_stop    <= 32'hFFFF_FFFF;
            r_min_h   <= '0;
            r_max_mag <= 13'sd3000;
            r_ra_b    <= 32'h7FFF_8000;
            r_de_b    <= 32'h7FFF_8000;
            r_moon_lo <= '0;
            r_moon_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vwd_pkg::REG_START:   r_start   <= i_cfg_data;
                vwd_pkg::REG_STOP:    r_stop    <= i_cfg_data;
                vwd_pkg::REG_MIN_H:   r_min_h   <= i_cfg_data[14:0];
                vwd_pkg::REG_MAX_MAG: r_max_mag <= i_cfg_data[12:0];
                vwd_pkg::REG_RA_RATE: r_ra_b    <= i_cfg_data;
                vwd_pkg::REG_DE_RATE: r_de_b    <= i_cfg_data;
                vwd_pkg::REG_MOON_LO: r_moon_lo <= i_cfg_data[16:0];
                vwd_pkg::REG_MOON_HI: r_moon_hi <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    vwd_pkg::t_rec cur;
    logic [2:0]    cls;
    logic          fast;
    logic          moon;
    logic          acc;
    logic [2:0]    n;
    logic [31:0]   tmask;

    assign tmask = (TB >= 32) ? 32'hFFFF_FFFF : ((32'd1 << TB) - 32'd1);

    // Classify the incoming sample.
    always_comb begin
        cur.time_v      = s_in.sample_time & tmask;
        cur.height      = s_in.height;
        cur.magnitude   = s_in.magnitude;
        cur.ra_rate     = s_in.ra_rate;
        cur.decl_rate   = s_in.decl_rate;
        cur.ra_position = s_in.ra_position;
        fast = (cur.ra_rate < $signed(r_ra_b[15:0])) || (cur.ra_rate > $signed(r_ra_b[31:16]))
            || (cur.decl_rate < $signed(r_de_b[15:0]))
            || (cur.decl_rate > $signed(r_de_b[31:16]));
        moon = ((r_moon_lo < r_moon_hi) && (cur.ra_position > r_moon_lo)
                && (cur.ra_position < r_moon_hi))
            || ((r_moon_hi < r_moon_lo) && ((cur.ra_position > r_moon_lo)
                || (cur.ra_position < r_moon_hi)));
        priority if (cur.time_v < (r_start & tmask))     cls = vwd_pkg::CLS_BEFORE;
        else if (cur.time_v >= (r_stop & tmask))         cls = vwd_pkg::CLS_AFTER;
        else if (s_in.in_shadow)                         cls = vwd_pkg::CLS_SHADOW;
        else if (cur.height < r_min_h)                   cls = vwd_pkg::CLS_LOW;
        else if (cur.magnitude > r_max_mag)              cls = vwd_pkg::CLS_DIM;
        else if (fast)                                   cls = vwd_pkg::CLS_FAST;
        else if (moon)                                   cls = vwd_pkg::CLS_MOON;
        else                                             cls = vwd_pkg::CLS_VISIBLE;
    end

    // Build result records for this sample.
    vwd_pkg::t_rec pk;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_ev[k] = '0;
        end
        n  = '0;
        pk = r_peak;
        if (cls != r_prev_cls) begin
            if (cls == vwd_pkg::CLS_VISIBLE) begin
                o_ev[0] = '{vwd_pkg::KIND_ENTRY, r_prev_cls, cur, 1'b0};
                n  = 3'd1;
                pk = cur;
            end else if (r_prev_cls == vwd_pkg::CLS_VISIBLE) begin
                o_ev[0] = '{vwd_pkg::KIND_PEAK, vwd_pkg::CLS_VISIBLE, r_peak, 1'b0};
                o_ev[1] = '{vwd_pkg::KIND_EXIT, cls, r_prev, 1'b0};
                n = 3'd2;
            end
        end
        if (cls == vwd_pkg::CLS_VISIBLE && pk.magnitude > cur.magnitude) begin
            pk = cur;
        end
        o_ev[n[1:0]] = '{vwd_pkg::KIND_SAMPLE, cls, cur, 1'b0};
        n = n + 3'd1;
        if (s_in.last_sample && cls == vwd_pkg::CLS_VISIBLE) begin
            o_ev[n[1:0]] = '{vwd_pkg::KIND_PEAK, vwd_pkg::CLS_VISIBLE, pk, 1'b0};
            o_ev[n[1:0] + 2'd1] = '{vwd_pkg::KIND_EXIT, vwd_pkg::CLS_AFTER, cur, 1'b0};
            n = n + 3'd2;
        end
        o_ev[n[1:0] - 2'd1].last_of_run = 1'b1;
    end

    // Accept only out of reset and when the queue can take the worst case.
    assign s_in.ready = i_rst_n && (i_free >= 3'd4);
    assign acc        = s_in.valid && s_in.ready;
    assign o_push_n   = acc ? n : 3'd0;

    // Advance run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cls <= vwd_pkg::CLS_BEFORE;
            r_prev     <= '0;
            r_peak     <= '0;
        end else if (acc) begin
            if (s_in.last_sample) begin
                r_prev_cls <= vwd_pkg::CLS_BEFORE;
                r_prev     <= '0;
                r_peak     <= '0;
            end else begin
                r_prev_cls <= cls;
                r_prev     <= cur;
                r_peak     <= pk;
            end
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/vwd_queue.sv @@
// Event queue between front and emitter: takes up to four records a cycle,
// hands out one. Depends on vwd_pkg.
`default_nettype none
module vwd_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire [2:0]       i_push_n,
    input  vwd_pkg::t_event i_ev [4],
    output logic [2:0]      o_free,
    vwd_event_if.source     m_out
);
    localparam int D = 8;
    vwd_pkg::t_event r_mem [D];
    logic [2:0] r_rd, r_wr;
    logic [3:0] r_cnt;
    logic       pop;

    assign pop      = m_out.valid && m_out.ready;
    assign o_free   = (r_cnt <= 4'd4) ? 3'd4 : 3'(4'd8 - r_cnt);
    assign m_out.valid = (r_cnt != 4'd0);
    assign m_out.event_kind        = r_mem[r_rd].event_kind;
    assign m_out.reason            = r_mem[r_rd].reason;
    assign m_out.event_time        = r_mem[r_rd].rec.time_v;
    assign m_out.event_height      = r_mem[r_rd].rec.height;
    assign m_out.event_magnitude   = r_mem[r_rd].rec.magnitude;
    assign m_out.event_ra_rate     = r_mem[r_rd].rec.ra_rate;
    assign m_out.event_decl_rate   = r_mem[r_rd].rec.decl_rate;
    assign m_out.event_ra_position = r_mem[r_rd].rec.ra_position;
    assign m_out.last_of_run       = r_mem[r_rd].last_of_run;

    // Store pushed records in order.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < i_push_n) begin
                r_mem[r_wr + 3'(k)] <= i_ev[k];
            end
        end
    end

    // Advance pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + i_push_n;
            r_rd  <= r_rd + {2'b0, pop};
            r_cnt <= r_cnt + {1'b0, i_push_n} - {3'b0, pop};
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/visibility_window_detector.sv @@
// Top level of the visibility window detector: front classifier and event queue.
// Depends on vwd_pkg, vwd_sample_if, vwd_event_if, vwd_front, vwd_queue.
//
//  channel  dir  handshake    payload
//  s_in     in   valid/ready  one sample
//  m_out    out  valid/ready  one result record
//  cfg      in   i_cfg_we     index, data
//
// A sample is classified and its one to four records are written to an
// eight-entry queue at the edge it is accepted; the first record is offered
// from the next cycle and one record leaves per cycle while m_out.ready is high.
// A sample is taken while at least four entries are free, so the rate is set
// by the output port: one record per cycle while m_out.ready is high. Reset
// is synchronous, active low; no sample is taken while it is held.
`default_nettype none
module visibility_window_detector #(
    parameter int TIME_BITS = vwd_pkg::TIME_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [vwd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [vwd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    vwd_sample_if.sink                    s_in,
    vwd_event_if.source                   m_out
);
    logic [2:0]      push_n;
    logic [2:0]      free;
    vwd_pkg::t_event ev [4];

    vwd_front #(.TIME_BITS(TIME_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .s_in(s_in), .i_free(free), .o_push_n(push_n),
        .o_ev(ev)
    );

    vwd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push_n(push_n), .i_ev(ev),
        .o_free(free), .m_out(m_out)
    );
endmodule
`default_nettype wire
